// ===== hdl/b64d_pkg.sv =====
// Shared types, constants and the character map of the base64url stream decoder.
`default_nettype none

package b64d_pkg;

   localparam logic [7:0] PAD_CHAR      = 8'h3D;   // '='
   localparam int         MAX_RESULTS   = 3;
   localparam int         FIFO_AW_DEF   = 3;       // result queue of eight items

   localparam logic [5:0] IDX_LOWER_BASE = 6'd26;
   localparam logic [5:0] IDX_DIGIT_BASE = 6'd52;
   localparam logic [5:0] IDX_PLUS       = 6'd62;
   localparam logic [5:0] IDX_SLASH      = 6'd63;

   // One result item.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_error;
      logic       last_of_run;
      logic       string_done;
   } result_type;

   // Everything one character produces, oldest result at index 0.
   typedef struct packed {
      logic [1:0]            count;
      result_type [2:0]      res;
   } dec_out_type;

   // Bit 6 set means the byte is not in either alphabet.
   function automatic logic [6:0] map_char(input logic [7:0] c);
      logic [6:0] v;
      v = 7'h40;
      case (c) inside
         [8'h41:8'h5A]: v = {1'b0, 6'(c - 8'h41)};
         [8'h61:8'h7A]: v = {1'b0, 6'(c - 8'h61) + IDX_LOWER_BASE};
         [8'h30:8'h39]: v = {1'b0, 6'(c - 8'h30) + IDX_DIGIT_BASE};
         8'h2D, 8'h2B:  v = {1'b0, IDX_PLUS};
         8'h5F, 8'h2F:  v = {1'b0, IDX_SLASH};
         default:       v = 7'h40;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/base64url_stream_decoder.sv =====
// Top level of the base64url stream decoder: input register, decoder and result queue.
//
//   channel | dir | tdata                | tuser                         | tlast
//   req_    | in  | [7:0] char_code      | -                             | end_of_string
//   rsp_    | out | [7:0] data_byte      | [0] is_error [1] last_of_run  | string_done
//
// A character is held in the input register, is decoded there and its zero to three
// result items are written into the result queue in the same cycle, so one character is
// taken every cycle while the queue has room for three more items.
// Reset clears the group state, the input register valid and the queue pointers.
// When the result side stalls, the queue fills and req_tready drops until space returns.
`default_nettype none

module base64url_stream_decoder #(
   parameter int FifoAw = b64d_pkg::FIFO_AW_DEF   // 2 or more
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,    // [7:0] char_code
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] data_byte
   output logic [1:0]  rsp_tuser,    // [0] is_error, [1] last_of_run
   output logic        rsp_tlast
);

   localparam int Depth = 1 << FifoAw;
   localparam logic [FifoAw:0] RoomLimit = (FifoAw + 1)'(Depth - b64d_pkg::MAX_RESULTS);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_char_ff;
   logic        in_last_ff;
   logic        consume;
   logic [1:0]  wr_n;
   logic        pop;

   b64d_pkg::dec_out_type dec_out;
   b64d_pkg::result_type  mem_ff [Depth];
   b64d_pkg::result_type  head;

   logic [FifoAw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FifoAw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FifoAw:0]   count_ff, count_in;

   b64d_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .step          (consume),
      .char_code     (in_char_ff),
      .end_of_string (in_last_ff),
      .dec_out       (dec_out)
   );

   always_comb begin
      consume     = in_valid_ff && (count_ff <= RoomLimit);
      req_tready  = !in_valid_ff || consume;
      in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !consume);
      wr_n        = consume ? dec_out.count : 2'd0;
      pop         = rsp_tvalid && rsp_tready;
      wr_ptr_in   = wr_ptr_ff + FifoAw'(wr_n);
      rd_ptr_in   = rd_ptr_ff + FifoAw'(pop);
      count_in    = count_ff + (FifoAw + 1)'(wr_n) - (FifoAw + 1)'(pop);
   end

   always_comb begin
      head       = mem_ff[rd_ptr_ff];
      rsp_tvalid = (count_ff != '0);
      rsp_tdata  = head.data_byte;
      rsp_tuser  = {head.last_of_run, head.is_error};
      rsp_tlast  = head.string_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < b64d_pkg::MAX_RESULTS; k++) begin
         if (2'(k) < wr_n) begin
            mem_ff[wr_ptr_ff + FifoAw'(k)] <= dec_out.res[k];
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/b64d_decode.sv =====
// Group state and per-character decode of the base64url stream decoder.
`default_nettype none

module b64d_decode (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       step,        // a character is taken this cycle
   input  wire  [7:0]                char_code,
   input  wire                       end_of_string,
   output b64d_pkg::dec_out_type     dec_out
);

   logic [17:0] sextet_buffer_ff, sextet_buffer_in;
   logic [1:0]  group_position_ff, group_position_in;
   logic        third_was_pad_ff, third_was_pad_in;
   logic        discarding_ff, discarding_in;

   logic [6:0]  mapped;
   logic        pad;
   logic        fail;
   logic [5:0]  sextet;
   logic [17:0] shifted;
   logic        twp_new;
   logic [23:0] triple;
   logic [7:0]  byte0, byte1, byte2;
   logic [1:0]  n_out;
   logic        err_out;

   always_comb begin
      mapped = b64d_pkg::map_char(char_code);
      pad    = (char_code == b64d_pkg::PAD_CHAR);
      sextet = pad ? 6'd0 : mapped[5:0];
      shifted = {sextet_buffer_ff[11:0], sextet};
      twp_new = (group_position_ff == 2'd2) ? pad : third_was_pad_ff;
      triple  = {sextet_buffer_ff, sextet};

      sextet_buffer_in  = sextet_buffer_ff;
      group_position_in = group_position_ff;
      third_was_pad_in  = third_was_pad_ff;
      discarding_in     = discarding_ff;
      byte0   = 8'd0;
      byte1   = 8'd0;
      byte2   = 8'd0;
      n_out   = 2'd0;
      err_out = 1'b0;

      fail = (pad && !group_position_ff[1])
          || (!pad && mapped[6])
          || (!pad && group_position_ff == 2'd3 && third_was_pad_ff)
          || (!pad && !mapped[6] && group_position_ff == 2'd0 && end_of_string);
      // A lone character at end of string would need '=' second, so it fails too;
      // a lone '=' is already covered by the early pad case.

      if (discarding_ff) begin
         if (end_of_string) begin
            sextet_buffer_in  = '0;
            group_position_in = '0;
            third_was_pad_in  = 1'b0;
            discarding_in     = 1'b0;
         end
      end else if (fail) begin
         sextet_buffer_in  = '0;
         group_position_in = '0;
         third_was_pad_in  = 1'b0;
         discarding_in     = !end_of_string;
         n_out   = 2'd1;
         err_out = 1'b1;
      end else if (group_position_ff != 2'd3) begin
         if (!end_of_string) begin
            sextet_buffer_in  = shifted;
            group_position_in = group_position_ff + 2'd1;
            third_was_pad_in  = twp_new;
         end else begin
            sextet_buffer_in  = '0;
            group_position_in = '0;
            third_was_pad_in  = 1'b0;
            if (group_position_ff == 2'd1) begin
               byte0 = shifted[11:4];
               n_out = 2'd1;
            end else begin
               byte0 = shifted[17:10];
               byte1 = shifted[9:2];
               n_out = twp_new ? 2'd1 : 2'd2;
            end
         end
      end else begin
         sextet_buffer_in  = '0;
         group_position_in = '0;
         third_was_pad_in  = 1'b0;
         byte0 = triple[23:16];
         byte1 = triple[15:8];
         byte2 = triple[7:0];
         n_out = third_was_pad_ff ? 2'd1 : (pad ? 2'd2 : 2'd3);
      end
   end

   always_comb begin
      dec_out.count = n_out;
      dec_out.res[0].data_byte = byte0;
      dec_out.res[1].data_byte = byte1;
      dec_out.res[2].data_byte = byte2;
      for (int k = 0; k < b64d_pkg::MAX_RESULTS; k++) begin
         dec_out.res[k].is_error    = err_out;
         dec_out.res[k].last_of_run = (n_out == 2'(k + 1));
         dec_out.res[k].string_done = (n_out == 2'(k + 1)) && (end_of_string || err_out);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sextet_buffer_ff  <= '0;
         group_position_ff <= '0;
         third_was_pad_ff  <= 1'b0;
         discarding_ff     <= 1'b0;
      end else if (step) begin
         sextet_buffer_ff  <= sextet_buffer_in;
         group_position_ff <= group_position_in;
         third_was_pad_ff  <= third_was_pad_in;
         discarding_ff     <= discarding_in;
      end
   end

endmodule

`default_nettype wire
